### src/tsr_pkg.sv
// shared types, constants and glyph font for the text scan-line rasterizer
package tsr_pkg;

    // pen and column positions (a drawing pen is below 127, plus at most 5 or 6 scaled glyph columns)
    localparam int PEN_W      = 8;
    localparam int SCALE_W    = 4;
    localparam int OX_W       = 7;
    localparam int OY_W       = 6;
    localparam int CODE_W     = 8;
    localparam int SCAN_W     = 6;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int BYTE_IDX_W = 4;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int PEN_ADV    = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SCALE = 2'd2;

    // character codes with glyphs
    localparam logic [7:0] CODE_ZERO  = 8'h30;
    localparam logic [7:0] CODE_NINE  = 8'h39;
    localparam logic [7:0] CODE_A     = 8'h41;
    localparam logic [7:0] CODE_Z     = 8'h5a;
    localparam logic [7:0] CODE_COLON = 8'h3a;
    localparam logic [7:0] CODE_DOT   = 8'h2e;
    localparam logic [7:0] CODE_DASH  = 8'h2d;
    localparam logic [7:0] CODE_SLASH = 8'h2f;
    localparam logic [7:0] CODE_GT    = 8'h3e;

    // column font, bit 0 is the top row
    localparam logic [0:9][0:4][7:0] DIGIT_ROM = {
        8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e,  8'h00, 8'h42, 8'h7f, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4b, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7f, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1e
    };

    localparam logic [0:25][0:4][7:0] LETTER_ROM = {
        8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e,  8'h7f, 8'h49, 8'h49, 8'h49, 8'h36,
        8'h3e, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c,
        8'h7f, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7f, 8'h09, 8'h09, 8'h09, 8'h01,
        8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a,  8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f,
        8'h00, 8'h41, 8'h7f, 8'h41, 8'h00,  8'h20, 8'h40, 8'h41, 8'h3f, 8'h01,
        8'h7f, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7f, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f,  8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f,
        8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e,  8'h7f, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e,  8'h7f, 8'h09, 8'h19, 8'h29, 8'h46,
        8'h46, 8'h49, 8'h49, 8'h49, 8'h31,  8'h01, 8'h01, 8'h7f, 8'h01, 8'h01,
        8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f,  8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f,
        8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
        8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h61, 8'h51, 8'h49, 8'h45, 8'h43
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic             accept;
        logic             calc;
        logic             draw;
        logic             emit;
        logic [COL_W-1:0] col;
    } tsr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic draw_en;
        logic out_free;
        logic byte_last;
    } tsr_status_t;

    // one glyph column for a code, zero for blank codes and columns past the glyph
    function automatic logic [7:0] glyph_slice(input logic [7:0] code,
                                               input logic [COL_W-1:0] col);
        logic [7:0] dig;
        logic [7:0] let_i;
        logic [7:0] res;
        dig   = code - CODE_ZERO;
        let_i = code - CODE_A;
        res   = 8'h00;
        if (col < COL_W'(GLYPH_COLS)) begin
            if (code inside {[CODE_ZERO:CODE_NINE]}) begin
                res = DIGIT_ROM[dig[3:0]][col];
            end else if (code inside {[CODE_A:CODE_Z]}) begin
                res = LETTER_ROM[let_i[4:0]][col];
            end else begin
                case (code)
                    CODE_COLON: res = (col == 3'd2) ? 8'h24 : 8'h00;
                    CODE_DOT:   res = (col == 3'd2) ? 8'h40 : 8'h00;
                    CODE_DASH:  res = (col < 3'd4) ? 8'h08 : 8'h00;
                    CODE_SLASH: res = 8'h40 >> col;
                    CODE_GT: begin
                        case (col)
                            3'd1:    res = 8'h22;
                            3'd2:    res = 8'h14;
                            3'd3:    res = 8'h08;
                            default: res = 8'h00;
                        endcase
                    end
                    default:    res = 8'h00;
                endcase
            end
        end
        return res;
    endfunction

endpackage

### src/tsr_ctrl.sv
// sequencing controller: accept, band check, per-column draw steps, line emit
module tsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    input  tsr_pkg::tsr_status_t status,
    output tsr_pkg::tsr_cmd_t    cmd
);
    import tsr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DRAW = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             last_reg, last_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        col_next   = col_reg;
        cmd        = '0;
        cmd.col    = col_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    last_next  = s_tlast;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                col_next = '0;
                if (status.draw_en) begin
                    state_next = ST_DRAW;
                end else if (last_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW: begin
                cmd.draw = 1'b1;
                col_next = col_reg + 1'b1;
                if (col_reg == COL_W'(GLYPH_COLS - 1)) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.byte_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            col_reg   <= col_next;
        end
    end

endmodule

### src/tsr_datapath.sv
// datapath: config registers, band and row math, line store, pen and output word register
module tsr_datapath #(
    parameter int LINE_PIXELS = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tsr_pkg::CODE_W-1:0]     in_code,
    input  logic [tsr_pkg::SCAN_W-1:0]     in_scan,
    input  tsr_pkg::tsr_cmd_t              cmd,
    output tsr_pkg::tsr_status_t           status,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [7:0]                     out_line_byte,
    output logic [tsr_pkg::BYTE_IDX_W-1:0] out_byte_index,
    output logic                           out_last_byte
);
    import tsr_pkg::*;

    localparam int LINE_BYTES = ((LINE_PIXELS / 8) > 16) ? 16 : (LINE_PIXELS / 8);
    localparam int LINE_LIMIT = LINE_BYTES * 8;
    localparam int BIDX_W     = $clog2(LINE_BYTES);

    // configuration
    logic [OX_W-1:0]    origin_x_reg;
    logic [OY_W-1:0]    origin_y_reg;
    logic [SCALE_W-1:0] scale_reg;

    // item and draw state
    logic [CODE_W-1:0]     code_reg;
    logic [SCAN_W-1:0]     scan_reg;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PEN_W-1:0]      pen_reg, pen_next;
    logic [PEN_W-1:0]      colpos_reg, colpos_next;
    logic                  run_start_reg, run_start_next;
    logic [LINE_LIMIT-1:0] line_reg, line_next;
    logic [BIDX_W-1:0]     bcnt_reg, bcnt_next;

    // output word register
    logic                  ovalid_reg, ovalid_next;
    logic [7:0]            obyte_reg;
    logic [BIDX_W-1:0]     oidx_reg;
    logic                  olast_reg;

    // combinational helpers
    logic [PEN_W-1:0]  pen_eff;
    logic [OY_W-1:0]   dy;
    logic [6:0]        span;
    logic              in_band;
    logic [ROW_W-1:0]  row_calc;
    logic [PEN_W-1:0]  col_hi;
    logic [LINE_LIMIT-1:0] span_mask;
    logic [7:0]        slice;
    logic              slice_on;
    logic [7:0]        sel_byte;
    logic              byte_last;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= SCALE_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg <= cfg_data[OX_W-1:0];
                CFG_ORIGIN_Y:   origin_y_reg <= cfg_data[OY_W-1:0];
                CFG_TEXT_SCALE: scale_reg    <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // pen at the start of this character
    assign pen_eff = run_start_reg ? PEN_W'(origin_x_reg) : pen_reg;

    // band test and glyph row: row counts how many whole scale steps fit in dy
    assign dy      = scan_reg - origin_y_reg;
    assign span    = 7'(scale_reg) * 7'(GLYPH_ROWS);
    assign in_band = (scan_reg >= origin_y_reg) && (7'(dy) < span)
                     && (pen_eff < PEN_W'(LINE_LIMIT - 1));

    always_comb begin
        row_calc = '0;
        for (int k = 1; k < GLYPH_ROWS; k++) begin
            if (7'(dy) >= 7'(scale_reg) * 7'(k)) begin
                row_calc = row_calc + 1'b1;
            end
        end
    end

    // pixel span of the current glyph column, clipped by the store width
    assign col_hi = colpos_reg + PEN_W'(scale_reg);
    always_comb begin
        for (int p = 0; p < LINE_LIMIT; p++) begin
            span_mask[p] = (PEN_W'(p) >= colpos_reg) && (PEN_W'(p) < col_hi);
        end
    end

    assign slice    = glyph_slice(code_reg, cmd.col);
    assign slice_on = slice[row_reg];

    // byte select for output, pixel 8k at bit 7
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sel_byte[7-i] = line_reg[{bcnt_reg, 3'b000} + i];
        end
    end
    assign byte_last = (bcnt_reg == BIDX_W'(LINE_BYTES - 1));

    assign status.draw_en   = in_band;
    assign status.out_free  = !ovalid_reg || m_tready;
    assign status.byte_last = byte_last;

    // line store, pen and byte counter
    always_comb begin
        row_next       = row_reg;
        pen_next       = pen_reg;
        colpos_next    = colpos_reg;
        run_start_next = run_start_reg;
        line_next      = line_reg;
        bcnt_next      = bcnt_reg;
        if (cmd.calc) begin
            row_next       = row_calc;
            colpos_next    = pen_eff;
            run_start_next = 1'b0;
            pen_next       = in_band ? (pen_eff + PEN_W'(7'(scale_reg) * 7'(PEN_ADV)))
                                     : pen_eff;
        end
        if (cmd.draw) begin
            colpos_next = col_hi;
            if (slice_on) begin
                line_next = line_reg | span_mask;
            end
        end
        if (cmd.emit) begin
            bcnt_next = bcnt_reg + 1'b1;
            if (byte_last) begin
                bcnt_next      = '0;
                line_next      = '0;
                pen_next       = '0;
                run_start_next = 1'b1;
            end
        end
    end

    // output valid
    always_comb begin
        ovalid_next = ovalid_reg;
        if (cmd.emit) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg       <= '0;
            run_start_reg <= 1'b1;
            line_reg      <= '0;
            bcnt_reg      <= '0;
            ovalid_reg    <= 1'b0;
        end else begin
            pen_reg       <= pen_next;
            run_start_reg <= run_start_next;
            line_reg      <= line_next;
            bcnt_reg      <= bcnt_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        colpos_reg <= colpos_next;
        if (cmd.accept) begin
            code_reg <= in_code;
            scan_reg <= in_scan;
        end
        if (cmd.emit) begin
            obyte_reg <= sel_byte;
            oidx_reg  <= bcnt_reg;
            olast_reg <= byte_last;
        end
    end

    assign m_tvalid       = ovalid_reg;
    assign out_line_byte  = obyte_reg;
    assign out_byte_index = BYTE_IDX_W'(oidx_reg);
    assign out_last_byte  = olast_reg;

endmodule

### src/text_scanline_rasterizer.sv
// top level of the text scan-line rasterizer: 5x7 column font into a line store
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata char_code, scan_line; s_tlast last_char
//  m_        out        m_tvalid/m_tready    m_tdata line_byte, byte_index; m_tlast last_byte
//  cfg_      in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// a character is accepted, then band checked, and ends there when it lies outside the band or the pen is past
// the line; when it draws, a draw step for each glyph column follows through the shared span mask unit.
// a last character then sends one word per cycle, 16 words for a 128-pixel line,
// held back by m_tready; the next character is taken once the last word is loaded.
// reset clears the line store, the pen, the byte count, output valid and the origins (text_scale comes up as 1).
// configuration writes are always taken.
module text_scanline_rasterizer #(
    parameter int LINE_PIXELS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [13:8] scan_line, [15:14] zero
    input  logic        s_tlast,   // last_char
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] line_byte, [11:8] byte_index, [15:12] zero
    output logic        m_tlast,   // last_byte
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import tsr_pkg::*;

    tsr_cmd_t              cmd;
    tsr_status_t           status;
    logic [7:0]            line_byte;
    logic [BYTE_IDX_W-1:0] byte_index;

    assign cfg_ready = 1'b1;

    // controller
    tsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    tsr_datapath #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_code        (s_tdata[7:0]),
        .in_scan        (s_tdata[13:8]),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_line_byte  (line_byte),
        .out_byte_index (byte_index),
        .out_last_byte  (m_tlast)
    );

    // pack the result word
    assign m_tdata = {4'b0000, byte_index, line_byte};

endmodule
